// ===== design/ihw_pkg.sv =====
package ihw_pkg;

    // One input request: a single character of the hex text
    typedef struct packed {
        logic [7:0] ch;
    } t_in_item;

    // One output request: a program word or the end marker
    typedef struct packed {
        logic [15:0] word_addr;
        logic [13:0] word_value;
        logic        end_of_file;
    } t_out_item;

    // Classified character as it travels from front to back
    typedef struct packed {
        logic       is_newline;
        logic       is_colon;
        logic [3:0] nibble;
    } t_token;

    localparam logic [7:0] C_CH_NEWLINE = 8'h0A;
    localparam logic [7:0] C_CH_COLON   = 8'h3A;
    localparam logic [7:0] C_CH_0       = 8'h30;
    localparam logic [7:0] C_CH_9       = 8'h39;
    localparam logic [7:0] C_CH_UA      = 8'h41;
    localparam logic [7:0] C_CH_UF      = 8'h46;
    localparam logic [7:0] C_CH_LA      = 8'h61;
    localparam logic [7:0] C_CH_LF      = 8'h66;

    localparam logic [7:0] C_REC_DATA     = 8'h00;
    localparam logic [7:0] C_REC_EOF      = 8'h01;
    localparam logic [7:0] C_REC_EXT_BASE = 8'h04;

    // Character positions within a record line
    localparam logic [9:0] C_POS_COUNT_LO  = 10'd1;
    localparam logic [9:0] C_POS_COUNT_END = 10'd2;
    localparam logic [9:0] C_POS_ADDR_LO   = 10'd3;
    localparam logic [9:0] C_POS_ADDR_END  = 10'd6;
    localparam logic [9:0] C_POS_TYPE_LO   = 10'd7;
    localparam logic [9:0] C_POS_TYPE_END  = 10'd8;
    localparam logic [9:0] C_POS_DATA_LO   = 10'd9;
    localparam logic [9:0] C_POS_DATA_END  = 10'd10;
    localparam logic [9:0] C_POS_BASE_END  = 10'd12;
    localparam logic [9:0] C_POS_MAX       = 10'd1023;

endpackage

// ===== design/ihw_stream_if.sv =====
interface ihw_in_if;
    logic              valid;
    logic              ready;
    ihw_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ihw_out_if;
    logic               valid;
    logic               ready;
    ihw_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ihw_front.sv =====
module ihw_front (
    ihw_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output ihw_pkg::t_token o_token
);

    logic [7:0] w_ch;

    assign w_ch       = i_in.data.ch;
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Non-hex characters decode as zero
    always_comb begin
        o_token.is_newline = (w_ch == ihw_pkg::C_CH_NEWLINE);
        o_token.is_colon   = (w_ch == ihw_pkg::C_CH_COLON);
        if (w_ch >= ihw_pkg::C_CH_0 && w_ch <= ihw_pkg::C_CH_9) begin
            o_token.nibble = w_ch[3:0];
        end else if ((w_ch >= ihw_pkg::C_CH_UA && w_ch <= ihw_pkg::C_CH_UF) ||
                     (w_ch >= ihw_pkg::C_CH_LA && w_ch <= ihw_pkg::C_CH_LF)) begin
            o_token.nibble = w_ch[3:0] + 4'd9;
        end else begin
            o_token.nibble = 4'd0;
        end
    end

endmodule

// ===== design/ihw_fifo.sv =====
module ihw_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ihw_pkg::t_token i_token,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ihw_pkg::t_token o_token
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ihw_pkg::t_token r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic [CW-1:0]   n_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_token = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_token;
        end
    end

endmodule

// ===== design/ihw_back.sv =====
module ihw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  ihw_pkg::t_token i_token,
    output logic            o_pop,
    ihw_out_if.source       o_out
);

    logic [9:0]  r_pos;
    logic        r_in_rec;
    logic        r_done;
    logic [15:0] r_acc;
    logic [7:0]  r_count;
    logic [15:0] r_addr;
    logic [7:0]  r_type;
    logic [15:0] r_base;
    logic [7:0]  r_low;
    logic        r_out_valid;
    ihw_pkg::t_out_item r_out;

    logic [9:0]  n_pos;
    logic        n_in_rec;
    logic        n_done;
    logic [15:0] n_acc;
    logic [7:0]  n_count;
    logic [15:0] n_addr;
    logic [7:0]  n_type;
    logic [15:0] n_base;
    logic [7:0]  n_low;
    logic        n_out_valid;
    ihw_pkg::t_out_item n_out;

    assign o_pop       = !i_empty && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        logic        field_start;
        logic [15:0] acc;
        logic [9:0]  pos_off;
        logic [8:0]  k;
        logic [8:0]  k_m1;
        logic [16:0] byte_addr;

        n_pos       = r_pos;
        n_in_rec    = r_in_rec;
        n_done      = r_done;
        n_acc       = r_acc;
        n_count     = r_count;
        n_addr      = r_addr;
        n_type      = r_type;
        n_base      = r_base;
        n_low       = r_low;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;

        field_start = (r_pos == ihw_pkg::C_POS_COUNT_LO) ||
                      (r_pos == ihw_pkg::C_POS_ADDR_LO)  ||
                      (r_pos == ihw_pkg::C_POS_TYPE_LO)  ||
                      (r_pos >= ihw_pkg::C_POS_DATA_LO && r_pos[0]);
        acc       = field_start ? {12'd0, i_token.nibble} : {r_acc[11:0], i_token.nibble};
        pos_off   = r_pos - ihw_pkg::C_POS_DATA_END;
        k         = pos_off[9:1];
        k_m1      = k - 9'd1;
        byte_addr = {1'b0, r_addr} + {8'd0, k_m1};

        if (o_pop && !r_done) begin
            if (i_token.is_newline) begin
                n_pos    = '0;
                n_in_rec = 1'b0;
            end else begin
                if (r_pos == '0) begin
                    n_in_rec = i_token.is_colon;
                end else if (r_in_rec) begin
                    n_acc = acc;
                    if (r_pos == ihw_pkg::C_POS_COUNT_END) begin
                        n_count = acc[7:0];
                    end else if (r_pos == ihw_pkg::C_POS_ADDR_END) begin
                        n_addr = acc;
                    end else if (r_pos == ihw_pkg::C_POS_TYPE_END) begin
                        n_type = acc[7:0];
                        if (acc[7:0] == ihw_pkg::C_REC_EOF) begin
                            n_done            = 1'b1;
                            n_out_valid       = 1'b1;
                            n_out.word_addr   = '0;
                            n_out.word_value  = '0;
                            n_out.end_of_file = 1'b1;
                        end
                    end else if (r_pos >= ihw_pkg::C_POS_DATA_END && !r_pos[0]) begin
                        if (r_type == ihw_pkg::C_REC_EXT_BASE &&
                            r_pos == ihw_pkg::C_POS_BASE_END) begin
                            n_base = acc;
                        end
                        if (r_type == ihw_pkg::C_REC_DATA && r_base == '0) begin
                            if (!k[0]) begin
                                if (k < {1'b0, r_count}) begin
                                    n_low = acc[7:0];
                                end
                            end else if (k <= {1'b0, r_count}) begin
                                // little-endian pair: high byte over held low byte
                                n_out_valid       = 1'b1;
                                n_out.word_addr   = byte_addr[16:1];
                                n_out.word_value  = {acc[5:0], r_low};
                                n_out.end_of_file = 1'b0;
                            end
                        end
                    end
                end
                if (r_pos != ihw_pkg::C_POS_MAX) begin
                    n_pos = r_pos + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_in_rec    <= 1'b0;
            r_done      <= 1'b0;
            r_acc       <= '0;
            r_count     <= '0;
            r_addr      <= '0;
            r_type      <= '0;
            r_base      <= '0;
            r_low       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_in_rec    <= n_in_rec;
            r_done      <= n_done;
            r_acc       <= n_acc;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_type      <= n_type;
            r_base      <= n_base;
            r_low       <= n_low;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// ===== design/intel_hex_word_parser_top.sv =====
// Intel HEX word parser. Characters of a hex file enter on i_in, one request
// per cycle while ready; 14-bit program words (with their word address) and a
// single end-of-file marker leave on o_out. The block sustains one character
// per clock while o_out is not stalled: the front stage decodes the character
// and writes it to a short token queue, the back stage walks the record fields
// and drives a registered output slot, so a stalled consumer only holds up
// input once the queue has filled. A character passes through the token queue and
// the output register before its word shows on o_out. After an end-of-file record
// all further characters are accepted and dropped until reset. Data records with
// a non-zero extended base (type 04) are dropped; checksums are not checked.
module intel_hex_word_parser_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ihw_in_if.sink    i_in,
    ihw_out_if.source o_out
);

    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_empty;
    ihw_pkg::t_token w_tok_in;
    ihw_pkg::t_token w_tok_out;

    // character decode and queue write
    ihw_front u_front (
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_token (w_tok_in)
    );

    // decouples input handshake from output back-pressure
    ihw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_tok_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_token (w_tok_out)
    );

    // record field parsing, word assembly, output register
    ihw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_token (w_tok_out),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ===== design/ihw_checker.sv =====
module ihw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_word_addr,
    input logic [13:0] i_word_value,
    input logic        i_end_of_file
);

    // stalled output request keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_word_addr) && $stable(i_word_value) &&
             $stable(i_end_of_file)))
        else $error("output request changed while stalled");

    // end marker carries zero address and value
    a_eof_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_end_of_file) |-> (i_word_addr == '0 && i_word_value == '0))
        else $error("end marker with non-zero payload");

    // nothing follows the end marker
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_end_of_file) |=> !i_out_valid)
        else $error("output after end marker");

    // reset empties the output slot
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid straight after reset");

endmodule

bind intel_hex_word_parser_top ihw_checker u_ihw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_word_addr   (o_out.data.word_addr),
    .i_word_value  (o_out.data.word_value),
    .i_end_of_file (o_out.data.end_of_file)
);

// ===== sim/ihw_word_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, predicts the word stream from the characters taken
// and compares every word request against the oldest prediction.
module ihw_word_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ihw_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ihw_pkg::t_out_item i_out_item,
    output int                 o_mismatches,
    output int                 o_outstanding,
    output int                 o_words,
    output int                 o_markers
);

    localparam int MAX_REPORTS = 40;

    // Decoder state
    logic [9:0]  line_pos;
    logic        in_colon_line;
    logic        eof_latched;
    logic [15:0] digit_acc;
    logic [7:0]  rec_count;
    logic [15:0] rec_addr;
    logic [7:0]  rec_kind;
    logic [15:0] ext_base;
    logic [7:0]  pending_lo;

    ihw_pkg::t_out_item expected_words[$];
    ihw_pkg::t_out_item want;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= ihw_pkg::C_CH_0 && c <= ihw_pkg::C_CH_9) d = c - ihw_pkg::C_CH_0;
        else if (c >= ihw_pkg::C_CH_UA && c <= ihw_pkg::C_CH_UF)
            d = c - ihw_pkg::C_CH_UA + 8'd10;
        else if (c >= ihw_pkg::C_CH_LA && c <= ihw_pkg::C_CH_LF)
            d = c - ihw_pkg::C_CH_LA + 8'd10;
        return d[3:0];
    endfunction

    task automatic absorb_char(input logic [7:0] c);
        logic [3:0]         nib;
        logic               starts_field;
        logic [9:0]         pair_idx;
        logic [7:0]         byte_val;
        logic [16:0]        byte_addr;
        ihw_pkg::t_out_item w;
        if (!eof_latched) begin
            if (c == ihw_pkg::C_CH_NEWLINE) begin
                line_pos      = '0;
                in_colon_line = 1'b0;
            end else begin
                if (line_pos == '0) begin
                    in_colon_line = (c == ihw_pkg::C_CH_COLON);
                end else if (in_colon_line) begin
                    nib = hex_value(c);
                    starts_field = (line_pos == ihw_pkg::C_POS_COUNT_LO) ||
                                   (line_pos == ihw_pkg::C_POS_ADDR_LO) ||
                                   (line_pos == ihw_pkg::C_POS_TYPE_LO) ||
                                   (line_pos >= ihw_pkg::C_POS_DATA_LO && line_pos[0]);
                    digit_acc = starts_field ? {12'd0, nib} : {digit_acc[11:0], nib};
                    if (line_pos == ihw_pkg::C_POS_COUNT_END) begin
                        rec_count = digit_acc[7:0];
                    end else if (line_pos == ihw_pkg::C_POS_ADDR_END) begin
                        rec_addr = digit_acc;
                    end else if (line_pos == ihw_pkg::C_POS_TYPE_END) begin
                        rec_kind = digit_acc[7:0];
                        if (rec_kind == ihw_pkg::C_REC_EOF) begin
                            eof_latched   = 1'b1;
                            w.word_addr   = '0;
                            w.word_value  = '0;
                            w.end_of_file = 1'b1;
                            expected_words.insert(expected_words.size(), w);
                        end
                    end else if (line_pos >= ihw_pkg::C_POS_DATA_END && !line_pos[0]) begin
                        pair_idx = (line_pos - ihw_pkg::C_POS_DATA_END) >> 1;
                        byte_val = digit_acc[7:0];
                        if (rec_kind == ihw_pkg::C_REC_EXT_BASE &&
                            line_pos == ihw_pkg::C_POS_BASE_END)
                            ext_base = digit_acc;
                        if (rec_kind == ihw_pkg::C_REC_DATA && ext_base == '0) begin
                            if (!pair_idx[0]) begin
                                if (pair_idx < {2'b00, rec_count}) pending_lo = byte_val;
                            end else if (pair_idx <= {2'b00, rec_count}) begin
                                byte_addr     = {1'b0, rec_addr} + {7'd0, pair_idx} - 17'd1;
                                w.word_addr   = byte_addr[16:1];
                                w.word_value  = {byte_val[5:0], pending_lo};
                                w.end_of_file = 1'b0;
                                expected_words.insert(expected_words.size(), w);
                            end
                        end
                    end
                end
                if (line_pos != ihw_pkg::C_POS_MAX) line_pos = line_pos + 10'd1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_pos      = '0;
            in_colon_line = 1'b0;
            eof_latched   = 1'b0;
            digit_acc     = '0;
            rec_count     = '0;
            rec_addr      = '0;
            rec_kind      = '0;
            ext_base      = '0;
            pending_lo    = '0;
            expected_words.delete();
            o_mismatches  = 0;
            o_outstanding = 0;
            o_words       = 0;
            o_markers     = 0;
        end else begin
            // Output side first: a word can never stem from a character taken this edge
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected word, expected none, %s %h value %h eof %b",
                                 $time, "got addr", i_out_item.word_addr,
                                 i_out_item.word_value, i_out_item.end_of_file);
                end else begin
                    want = expected_words.pop_front();
                    if (want.word_addr !== i_out_item.word_addr ||
                        want.word_value !== i_out_item.word_value ||
                        want.end_of_file !== i_out_item.end_of_file) begin
                        o_mismatches++;
                        if (o_mismatches <= MAX_REPORTS)
                            $display("%0t: expected addr %h value %h eof %b, %s %h %s %h %s %b",
                                     $time, want.word_addr, want.word_value, want.end_of_file,
                                     "got addr", i_out_item.word_addr,
                                     "value", i_out_item.word_value,
                                     "eof", i_out_item.end_of_file);
                    end
                    if (want.end_of_file) o_markers++;
                    else o_words++;
                end
            end
            if (i_in_valid && i_in_ready) absorb_char(i_in_item.ch);
            o_outstanding = expected_words.size();
        end
    end

endmodule

// ===== sim/tb_intel_hex_word_parser_top.sv =====
`timescale 1ns / 1ps

// Testbench top: builds a hex text, feeds it one character per request with
// random gaps, stalls the word side at random and gives the verdict. All
// prediction and comparison sits in the checker.
module tb_intel_hex_word_parser_top;

    localparam int          TEXT_CHARS   = 1150;
    localparam int          EOF_TAIL     = 60;   // room for the closing lines
    localparam int          CYCLE_LIMIT  = 2000000;
    localparam int          TAIL_CYCLES  = 24;
    localparam logic [7:0]  C_CH_CR      = 8'h0D;
    // Record types the parser simply skips
    localparam logic [7:0]  C_REC_EXT_SEG   = 8'h02;
    localparam logic [7:0]  C_REC_START_SEG = 8'h03;
    localparam logic [7:0]  C_REC_START_LIN = 8'h05;
    // Where a record gets a character overwritten
    localparam int          GARBLE_NONE   = 0;
    localparam int          GARBLE_HEADER = 1;
    localparam int          GARBLE_BODY   = 2;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ihw_in_if  char_if ();
    ihw_out_if word_if ();

    int mismatches;
    int outstanding;
    int words_seen;
    int markers_seen;
    int cycle_count = 0;
    int line_total  = 0;

    logic [7:0] hex_text[$];   // whole character stream, built up front
    logic [7:0] line_buf[$];   // record line under construction
    logic [7:0] payload[$];    // data bytes of the next record

    always #6 i_clk = ~i_clk;

    intel_hex_word_parser_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_if),
        .o_out   (word_if)
    );

    ihw_word_checker word_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (char_if.valid),
        .i_in_ready    (char_if.ready),
        .i_in_item     (char_if.data),
        .i_out_valid   (word_if.valid),
        .i_out_ready   (word_if.ready),
        .i_out_item    (word_if.data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_words       (words_seen),
        .o_markers     (markers_seen)
    );

    // Mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            calm = $urandom_range(20, 150);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return ihw_pkg::C_CH_0 + {4'd0, n};
        return (lower ? ihw_pkg::C_CH_LA : ihw_pkg::C_CH_UA) + {4'd0, n} - 8'd10;
    endfunction

    // Any byte but newline, so a noise run never opens a fresh line
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == ihw_pkg::C_CH_NEWLINE);
        return c;
    endfunction

    task automatic add_text(input logic [7:0] c);
        hex_text.insert(hex_text.size(), c);
    endtask

    task automatic add_line_char(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endtask

    task automatic end_line(input bit crlf);
        if (crlf) add_text(C_CH_CR);
        add_text(ihw_pkg::C_CH_NEWLINE);
        line_total++;
    endtask

    task automatic buf_byte(input logic [7:0] v, input bit lower);
        add_line_char(hex_char(v[7:4], lower));
        add_line_char(hex_char(v[3:0], lower));
    endtask

    task automatic fill_payload(input int n);
        repeat (n) payload.insert(payload.size(), 8'($urandom_range(0, 255)));
    endtask

    // Full record from payload with a true checksum; optional cut and one
    // overwritten character. The type characters are never touched, so
    // nothing but the final record can end the file.
    task automatic put_record(input logic [7:0] count, input logic [15:0] addr,
                              input logic [7:0] kind, input bit lower,
                              input int cut, input int garble);
        logic [7:0] sum;
        int         at;
        line_buf.delete();
        add_line_char(ihw_pkg::C_CH_COLON);
        sum = count + addr[15:8] + addr[7:0] + kind;
        buf_byte(count, lower);
        buf_byte(addr[15:8], lower);
        buf_byte(addr[7:0], lower);
        buf_byte(kind, lower);
        foreach (payload[i]) begin
            buf_byte(payload[i], lower);
            sum = sum + payload[i];
        end
        buf_byte(8'd0 - sum, lower);
        if (garble == GARBLE_HEADER) begin
            at = $urandom_range(1, 6);
            line_buf[at] = noise_char();
        end else if (garble == GARBLE_BODY) begin
            at = $urandom_range(9, line_buf.size() - 1);
            line_buf[at] = noise_char();
        end
        if (cut >= 0)
            while (line_buf.size() > cut) void'(line_buf.pop_back());
        foreach (line_buf[i]) add_text(line_buf[i]);
        end_line($urandom_range(0, 3) == 0);
        payload.delete();
    endtask

    task automatic put_noise_line(input int len);
        logic [7:0] c;
        if (len > 0) begin
            do c = noise_char(); while (c == ihw_pkg::C_CH_COLON);
            add_text(c);
            repeat (len - 1) add_text(noise_char());
        end
        end_line(1'b0);
    endtask

    task automatic add_random_line();
        int          pick;
        int          cnt;
        int          cut;
        bit          lower;
        logic [15:0] addr;
        logic [15:0] base;
        pick  = $urandom_range(0, 99);
        lower = ($urandom_range(0, 3) == 0);
        addr  = 16'($urandom_range(0, 16'hFFFF));
        cnt   = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
        if (pick < 58) begin
            fill_payload(cnt);
            put_record(8'(cnt), addr, ihw_pkg::C_REC_DATA, lower, -1, GARBLE_NONE);
        end else if (pick < 66) begin
            fill_payload(cnt);
            put_record(8'(cnt), addr, ihw_pkg::C_REC_DATA, lower,
                       $urandom_range(1, 10 + 2 * cnt), GARBLE_NONE);
        end else if (pick < 72) begin
            fill_payload(cnt);
            put_record(8'(cnt), addr, ihw_pkg::C_REC_DATA, lower, -1, GARBLE_BODY);
        end else if (pick < 76) begin
            fill_payload(cnt);
            put_record(8'(cnt), addr, ihw_pkg::C_REC_DATA, lower, -1, GARBLE_HEADER);
        end else if (pick < 82) begin
            // Base mostly back to zero so data keeps flowing
            base = ($urandom_range(0, 3) != 0) ? 16'h0000 : 16'($urandom_range(1, 16'hFFFF));
            payload.insert(payload.size(), base[15:8]);
            payload.insert(payload.size(), base[7:0]);
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : -1;
            put_record(8'd2, 16'h0000, ihw_pkg::C_REC_EXT_BASE, lower, cut, GARBLE_NONE);
        end else if (pick < 87) begin
            fill_payload(cnt);
            put_record(8'(cnt), addr, 8'($urandom_range(2, 255)), lower, -1, GARBLE_NONE);
        end else if (pick < 96) begin
            put_noise_line($urandom_range(0, 30));
        end else begin
            end_line($urandom_range(0, 1) == 1);
        end
    endtask

    task automatic send_char(input logic [7:0] c, input int gap);
        if (gap > 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_if.valid   <= 1'b1;
        char_if.data.ch <= c;
        do @(posedge i_clk); while (!char_if.ready);
    endtask

    // Word side: random back-pressure
    initial begin : word_sink
        int gap;
        int calm;
        word_if.ready = 1'b0;
        calm = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = pick_gap(calm);
            if (gap > 0) begin
                word_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            word_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d words outstanding",
                 cycle_count, outstanding);
        $display("Mismatches found");
        $finish;
    end

    initial begin : char_source
        int calm;
        char_if.valid = 1'b0;
        char_if.data  = '0;
        calm = 0;

        // ---- directed text ----
        end_line(1'b0);                                   // empty line
        put_noise_line(12);                               // comment line, ignored
        payload = '{8'hFF, 8'hFF};                        // all-ones word, masked to 14 bits
        put_record(8'd2, 16'h0000, ihw_pkg::C_REC_DATA, 1'b0, -1, GARBLE_NONE);
        payload = '{8'h00, 8'h11, 8'h22};                 // odd count: checksum is last high byte
        put_record(8'd3, 16'h0010, ihw_pkg::C_REC_DATA, 1'b0, -1, GARBLE_NONE);
        payload = '{8'hAB, 8'hCD, 8'hEF, 8'h01};          // lower-case digits
        put_record(8'd4, 16'h1234, ihw_pkg::C_REC_DATA, 1'b1, -1, GARBLE_NONE);
        put_record(8'd0, 16'h0000, ihw_pkg::C_REC_DATA, 1'b0, -1, GARBLE_NONE);
        fill_payload(255);                                // largest count at top address
        put_record(8'hFF, 16'hFFFF, ihw_pkg::C_REC_DATA, 1'b0, -1, GARBLE_NONE);
        fill_payload(6);                                  // non-hex character in the data
        put_record(8'd6, 16'h0100, ihw_pkg::C_REC_DATA, 1'b0, -1, GARBLE_BODY);
        fill_payload(4);                                  // non-hex character in the header
        put_record(8'd4, 16'h0200, ihw_pkg::C_REC_DATA, 1'b0, -1, GARBLE_HEADER);
        fill_payload(4);                                  // line ends inside the address
        put_record(8'd4, 16'h0300, ihw_pkg::C_REC_DATA, 1'b0, 4, GARBLE_NONE);
        fill_payload(4);                                  // ends after a low byte
        put_record(8'd4, 16'h0400, ihw_pkg::C_REC_DATA, 1'b0, 11, GARBLE_NONE);
        fill_payload(4);                                  // one word, then the line ends
        put_record(8'd4, 16'h0500, ihw_pkg::C_REC_DATA, 1'b0, 13, GARBLE_NONE);
        payload = '{8'h12, 8'h34};                        // short base record: no change
        put_record(8'd2, 16'h0000, ihw_pkg::C_REC_EXT_BASE, 1'b0, 11, GARBLE_NONE);
        payload = '{8'h00, 8'h01};                        // base above 64K
        put_record(8'd2, 16'h0000, ihw_pkg::C_REC_EXT_BASE, 1'b0, -1, GARBLE_NONE);
        fill_payload(4);                                  // dropped
        put_record(8'd4, 16'h0600, ihw_pkg::C_REC_DATA, 1'b0, -1, GARBLE_NONE);
        payload = '{8'h00, 8'h00};                        // back to the low 64K
        put_record(8'd2, 16'h0000, ihw_pkg::C_REC_EXT_BASE, 1'b1, -1, GARBLE_NONE);
        fill_payload(4);
        put_record(8'd4, 16'h0008, C_REC_EXT_SEG, 1'b0, -1, GARBLE_NONE);
        fill_payload(4);
        put_record(8'd4, 16'h0000, C_REC_START_SEG, 1'b0, -1, GARBLE_NONE);
        fill_payload(4);
        put_record(8'd4, 16'h0000, C_REC_START_LIN, 1'b0, -1, GARBLE_NONE);
        fill_payload(4);
        put_record(8'd4, 16'h0700, ihw_pkg::C_REC_DATA, 1'b0, -1, GARBLE_NONE);
        put_noise_line(30);

        // ---- random text ----
        while (hex_text.size() < TEXT_CHARS - EOF_TAIL) add_random_line();

        // ---- end of file, then text that must be ignored ----
        put_record(8'd0, 16'h0000, ihw_pkg::C_REC_EOF, 1'b0, -1, GARBLE_NONE);
        fill_payload(4);
        put_record(8'd4, 16'h0000, ihw_pkg::C_REC_DATA, 1'b0, -1, GARBLE_NONE);
        put_noise_line(20);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (hex_text[i]) send_char(hex_text[i], pick_gap(calm));
        char_if.valid <= 1'b0;

        // Let the checker see the last acceptance before looking at the backlog
        @(posedge i_clk);
        wait (outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Fed %0d characters on %0d lines: extreme, odd, broken and noise records, %s",
                 hex_text.size(), line_total, "base changes, skipped types, end of file");
        $display("Checked %0d program words and %0d end marker(s) in %0d cycles",
                 words_seen, markers_seen, cycle_count);
        if (mismatches == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ihw_pkg.sv
design/ihw_stream_if.sv
design/ihw_front.sv
design/ihw_fifo.sv
design/ihw_back.sv
design/intel_hex_word_parser_top.sv
design/ihw_checker.sv
sim/ihw_word_checker.sv
sim/tb_intel_hex_word_parser_top.sv
